/* src/bitmap_block_allocator_macros.svh */
// ----------------------------------------------------------------------------
// bitmap block allocator assertion macros
// shared property wrappers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// constants, types and helper functions of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_BLOCKS  = 1024;
  localparam int MAX_REQUEST = 16;
  localparam int WORD_W      = 32;
  localparam int NUM_WORDS   = NUM_BLOCKS / WORD_W;
  localparam int WADDR_W     = $clog2(NUM_WORDS);
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int BLK_W       = 10;
  localparam int CNT_W       = 5;
  localparam int PC_W        = $clog2(WORD_W + 1);
  localparam int SUM_W       = $clog2(MAX_REQUEST + WORD_W + 1);

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_FAIL  = 2'd1,
    ST_FREED = 2'd2
  } status_e;

  // number of set bits in one map word
  function automatic logic [PC_W-1:0] popcount(input word_t w);
    logic [PC_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) begin
      c = c + PC_W'(w[i]);
    end
    return c;
  endfunction

  // position of the single set bit of a one-hot word
  function automatic logic [BIT_W-1:0] onehot_index(input word_t oh);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (oh[i]) begin
        r = r | BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* src/bitmap_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit block allocator over a one-bit-per-block used map
// ----------------------------------------------------------------------------
// The used map lives in a 32-word by 32-bit ram with a registered read port;
// a valid bit per word makes every block free straight out of reset, so there
// is no clearing pass. One request is handled at a time. A free request is
// accepted with its word read issued, then modifies and writes the word back
// and gives one result; an allocate with a bad count or an out-of-range
// first_data_block goes straight to a failure result. An allocate request
// first counts free blocks word by word from first_data_block, one word per
// cycle, and stops as soon as enough are seen or the map ends, so it fails
// with the map untouched. On success the same words are read again, and each
// allocated block is handed out in turn, its word written back when it is
// exhausted or the request is done. Up to 32 words are scanned and the count
// is at most 16; the result side can hold back the handing out of blocks.
// The ram read port sets the one-word-per-cycle pace. Results sit in an
// output register, so a request may be accepted while the previous result
// still waits to be taken.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [bba_pkg::BLK_W-1:0]   cfg_wdata_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [0:0]                  opcode_i,
  input  logic [bba_pkg::CNT_W-1:0]   alloc_count_i,
  input  logic [bba_pkg::BLK_W-1:0]   block_index_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bba_pkg::BLK_W-1:0]   block_number_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);

  localparam int WADDR_W = bba_pkg::WADDR_W;
  localparam int BIT_W   = bba_pkg::BIT_W;

  // one-hot sequencer
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CNT  = 6'b000010,
    S_LOAD = 6'b000100,
    S_EMIT = 6'b001000,
    S_FREE = 6'b010000,
    S_FAIL = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration register
  logic [bba_pkg::BLK_W-1:0] fdb_q;

  // request context
  logic [bba_pkg::CNT_W-1:0] count_q, count_d;
  logic [bba_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [bba_pkg::SUM_W-1:0] found_q, found_d;
  logic [WADDR_W-1:0]        addr_q, addr_d;
  logic                      first_q, first_d;
  bba_pkg::word_t            work_q, work_d;
  bba_pkg::word_t            avail_q, avail_d;
  logic [bba_pkg::BLK_W-1:0] free_idx_q, free_idx_d;
  logic                      free_ok_q, free_ok_d;

  // word valid bits, a word never written reads as all free
  logic [bba_pkg::NUM_WORDS-1:0] valid_q, valid_d;
  logic                          rd_valid_q;

  // ram port
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  bba_pkg::word_t       ram_wdata;
  logic                 ram_re;
  logic [WADDR_W-1:0]   ram_raddr;
  bba_pkg::word_t       ram_rdata;

  // output register
  logic                      out_valid_q;
  logic [bba_pkg::BLK_W-1:0] block_number_q, nb_d;
  bba_pkg::status_e          status_q, st_d;
  logic                      last_q, last_d;
  logic                      out_load;

  // datapath
  bba_pkg::word_t            rd_word;
  bba_pkg::word_t            first_mask;
  bba_pkg::word_t            free_bits;
  logic [bba_pkg::SUM_W-1:0] sum;
  logic [WADDR_W-1:0]        fdb_word;
  logic [WADDR_W-1:0]        addr_nxt;
  logic                      fdb_ok;
  logic                      count_ok;
  logic                      free_in_range;
  bba_pkg::word_t            pick_oh;
  logic [BIT_W-1:0]          pick_bit;
  bba_pkg::word_t            avail_left;
  logic                      slot_free;
  logic                      final_pick;

  bba_ram #(
    .WIDTH (bba_pkg::WORD_W),
    .DEPTH (bba_pkg::NUM_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_word    = rd_valid_q ? ram_rdata : '0;
  // the first word of a scan only counts bits at or above the start block
  assign first_mask = first_q ? ({bba_pkg::WORD_W{1'b1}} << fdb_q[BIT_W-1:0])
                              : {bba_pkg::WORD_W{1'b1}};
  assign free_bits  = ~rd_word & first_mask;
  assign sum        = found_q + bba_pkg::SUM_W'(bba_pkg::popcount(free_bits));

  assign fdb_word      = WADDR_W'(fdb_q >> BIT_W);
  assign addr_nxt      = WADDR_W'(addr_q + 1'b1);
  assign fdb_ok        = int'(fdb_q) < bba_pkg::NUM_BLOCKS;
  assign count_ok      = (alloc_count_i != '0) && (int'(alloc_count_i) <= bba_pkg::MAX_REQUEST);
  assign free_in_range = int'(block_index_i) < bba_pkg::NUM_BLOCKS;

  // lowest free bit of the word being handed out
  assign pick_oh    = avail_q & (~avail_q + bba_pkg::word_t'(1));
  assign pick_bit   = bba_pkg::onehot_index(pick_oh);
  assign avail_left = avail_q & ~pick_oh;
  assign final_pick = rem_q == bba_pkg::CNT_W'(1);

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rem_d      = rem_q;
    found_d    = found_q;
    addr_d     = addr_q;
    first_d    = first_q;
    work_d     = work_q;
    avail_d    = avail_q;
    free_idx_d = free_idx_q;
    free_ok_d  = free_ok_q;
    valid_d    = valid_q;
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = work_q;
    ram_re     = 1'b0;
    ram_raddr  = addr_q;
    out_load   = 1'b0;
    nb_d       = block_number_q;
    st_d       = status_q;
    last_d     = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == bba_pkg::OP_FREE) begin
            // fetch the word holding the block to free
            free_idx_d = block_index_i;
            free_ok_d  = free_in_range;
            addr_d     = WADDR_W'(block_index_i >> BIT_W);
            ram_re     = free_in_range;
            ram_raddr  = WADDR_W'(block_index_i >> BIT_W);
            state_d    = S_FREE;
          end else if (count_ok && fdb_ok) begin
            // start the counting pass at the first data block
            count_d   = alloc_count_i;
            rem_d     = alloc_count_i;
            found_d   = '0;
            addr_d    = fdb_word;
            first_d   = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = fdb_word;
            state_d   = S_CNT;
          end else begin
            state_d = S_FAIL;
          end
        end
      end

      S_CNT: begin
        if (sum >= bba_pkg::SUM_W'(count_q)) begin
          // enough free blocks, rescan from the start and hand them out
          addr_d    = fdb_word;
          first_d   = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = fdb_word;
          state_d   = S_LOAD;
        end else if (addr_q == WADDR_W'(bba_pkg::NUM_WORDS - 1)) begin
          state_d = S_FAIL;
        end else begin
          found_d   = sum;
          addr_d    = addr_nxt;
          first_d   = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = addr_nxt;
        end
      end

      S_LOAD: begin
        if (free_bits == '0) begin
          // nothing free here, move straight on
          addr_d    = addr_nxt;
          first_d   = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = addr_nxt;
        end else begin
          work_d  = rd_word;
          avail_d = free_bits;
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          nb_d     = bba_pkg::BLK_W'({addr_q, pick_bit});
          st_d     = bba_pkg::ST_ALLOC;
          last_d   = final_pick;
          rem_d    = rem_q - 1'b1;
          work_d   = work_q | pick_oh;
          avail_d  = avail_left;
          if (final_pick || (avail_left == '0)) begin
            // word done, write it back and, unless the request is done, fetch the next one
            ram_we           = 1'b1;
            ram_waddr        = addr_q;
            ram_wdata        = work_q | pick_oh;
            valid_d[addr_q]  = 1'b1;
            if (final_pick) begin
              state_d = S_IDLE;
            end else begin
              addr_d    = addr_nxt;
              first_d   = 1'b0;
              ram_re    = 1'b1;
              ram_raddr = addr_nxt;
              state_d   = S_LOAD;
            end
          end
        end
      end

      S_FREE: begin
        if (slot_free) begin
          out_load = 1'b1;
          nb_d     = free_idx_q;
          st_d     = bba_pkg::ST_FREED;
          last_d   = 1'b1;
          if (free_ok_q) begin
            ram_we          = 1'b1;
            ram_waddr       = addr_q;
            ram_wdata       = rd_word & ~(bba_pkg::word_t'(1) << free_idx_q[BIT_W-1:0]);
            valid_d[addr_q] = 1'b1;
          end
          state_d = S_IDLE;
        end
      end

      S_FAIL: begin
        if (slot_free) begin
          out_load = 1'b1;
          nb_d     = '0;
          st_d     = bba_pkg::ST_FAIL;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fdb_q       <= '0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        fdb_q <= cfg_wdata_i;
      end
      if (ram_re) begin
        rd_valid_q <= valid_q[ram_raddr];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request context and result payload
  always_ff @(posedge clk_i) begin
    count_q        <= count_d;
    rem_q          <= rem_d;
    found_q        <= found_d;
    addr_q         <= addr_d;
    first_q        <= first_d;
    work_q         <= work_d;
    avail_q        <= avail_d;
    free_idx_q     <= free_idx_d;
    free_ok_q      <= free_ok_d;
    block_number_q <= nb_d;
    status_q       <= st_d;
    last_q         <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign block_number_o = block_number_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

  `BBA_ASSERT_IMPL(a_emit_live, (state_q == S_EMIT), (avail_q != '0 && rem_q != '0), "emit with nothing to hand out")
  `BBA_ASSERT_IMPL(a_no_rw_clash, (ram_we && ram_re), (ram_waddr != ram_raddr), "map read and write hit one word")
  `BBA_ASSERT_NEXT(a_last_ends, (out_load && last_d), (state_q == S_IDLE), "final result without return to idle")
  `BBA_ASSERT_NEXT(a_one_request, (in_valid_i && in_ready_o), (!in_ready_o), "second request taken while busy")

endmodule

/* src/bba_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
